/* rtl/esflp_pkg.sv */
// Shared types, character codes and keyword tables for the event-stream field line parser.
`default_nettype none

package esflp_pkg;

	// field kind codes as reported on field_kind
	typedef enum logic [2:0] {
		KIND_NONE  = 3'd0,
		KIND_EVENT = 3'd1,
		KIND_DATA  = 3'd2,
		KIND_ID    = 3'd3,
		KIND_RETRY = 3'd4
	} kind_t;

	// line phase, one-hot
	typedef enum logic [2:0] {
		PH_START = 3'b001,
		PH_NAME  = 3'b010,
		PH_VALUE = 3'b100
	} phase_t;

	localparam logic [7:0]  CH_COLON  = 8'h3A;
	localparam logic [7:0]  CH_SPACE  = 8'h20;
	localparam logic [7:0]  CH_TAB    = 8'h09;
	localparam logic [7:0]  CH_CR     = 8'h0D;
	localparam logic [7:0]  CH_ZERO   = 8'h30;
	localparam logic [7:0]  CH_NINE   = 8'h39;
	localparam logic [30:0] RETRY_MAX = 31'h7FFF_FFFF;

	localparam int unsigned NUM_KW    = 4;
	localparam int unsigned NAME_LEN_MAX = 7;

	// line control -> retry parser
	typedef struct packed {
		logic       clear;
		logic       feed;
		logic [7:0] data;
	} retry_ctl_t;

	// retry parser -> line control
	typedef struct packed {
		logic        seen_digit;
		logic        invalid;
		logic [30:0] value;
	} retry_stat_t;

	// one result word
	typedef struct packed {
		logic        value_valid;
		logic [7:0]  value_byte;
		logic        line_done;
		kind_t       kind;
		logic        status;
		logic [30:0] retry_value;
	} res_t;

	// keyword length: event, data, id, retry
	function automatic logic [2:0] kw_len(input logic [1:0] k);
		case (k)
			2'd0:    kw_len = 3'd5;
			2'd1:    kw_len = 3'd4;
			2'd2:    kw_len = 3'd2;
			2'd3:    kw_len = 3'd5;
			default: kw_len = 3'd0;
		endcase
	endfunction

	// keyword character at a position, zero past the end
	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
		logic [39:0] txt;
		case (k)
			2'd0:    txt = "event";
			2'd1:    txt = {"data", 8'h00};
			2'd2:    txt = {"id", 24'h0};
			2'd3:    txt = "retry";
			default: txt = '0;
		endcase
		case (pos)
			3'd0:    kw_char = txt[39:32];
			3'd1:    kw_char = txt[31:24];
			3'd2:    kw_char = txt[23:16];
			3'd3:    kw_char = txt[15:8];
			3'd4:    kw_char = txt[7:0];
			default: kw_char = 8'h00;
		endcase
	endfunction

	// lowest surviving keyword whose length equals the name length
	function automatic kind_t matched_kind(input logic [3:0] cand, input logic [2:0] len);
		kind_t k_out;
		k_out = KIND_NONE;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (cand[k] && len == kw_len(2'(k)))
				k_out = kind_t'(3'(k + 1));
		end
		return k_out;
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
	endfunction

endpackage

`default_nettype wire

/* rtl/esflp_retry.sv */
// Retry value decimal parser with whitespace trim and overflow check.
`default_nettype none

module esflp_retry (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire esflp_pkg::retry_ctl_t ctl,
	output esflp_pkg::retry_stat_t     stat
);
	import esflp_pkg::*;

	logic [30:0] acc_q;
	logic        seen_q;
	logic        trail_q;
	logic        invalid_q;

	logic [34:0] prod;
	logic        is_digit;

	assign is_digit = (ctl.data >= CH_ZERO) && (ctl.data <= CH_NINE);
	// acc * 10 + digit, acc <= 2^31-1 so 35 bits hold it
	assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ {27'b0, ctl.data - CH_ZERO};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			seen_q    <= 1'b0;
			trail_q   <= 1'b0;
			invalid_q <= 1'b0;
		end else if (ctl.clear) begin
			acc_q     <= '0;
			seen_q    <= 1'b0;
			trail_q   <= 1'b0;
			invalid_q <= 1'b0;
		end else if (ctl.feed && !invalid_q) begin
			if (is_ws(ctl.data)) begin
				if (seen_q)
					trail_q <= 1'b1;
			end else if (!is_digit || trail_q) begin
				invalid_q <= 1'b1;
			end else begin
				seen_q <= 1'b1;
				if (prod > {4'b0, RETRY_MAX})
					invalid_q <= 1'b1;
				else
					acc_q <= prod[30:0];
			end
		end
	end

	assign stat.seen_digit = seen_q;
	assign stat.invalid    = invalid_q;
	assign stat.value      = acc_q;

endmodule

`default_nettype wire

/* rtl/esflp_line_ctl.sv */
// Line state: comment detect, field name match, value routing and terminator report.
`default_nettype none

module esflp_line_ctl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire logic [7:0]             line_byte,
	input  wire logic                   end_of_line,
	input  wire esflp_pkg::retry_stat_t rstat,
	output esflp_pkg::retry_ctl_t       rctl,
	output logic                        produce,
	output esflp_pkg::res_t             res
);
	import esflp_pkg::*;

	phase_t     phase_q;
	logic [2:0] name_len_q;
	logic [3:0] cand_q;
	logic       comment_q;
	kind_t      vkind_q;
	logic       first_q;

	logic       is_colon;
	logic       drop_space;
	logic [3:0] cand_next;
	kind_t      end_kind;
	logic       end_bad;
	logic       vbyte_fwd;

	assign is_colon   = (line_byte == CH_COLON);
	assign drop_space = first_q && (line_byte == CH_SPACE);

	always_comb begin
		cand_next = cand_q;
		for (int k = 0; k < NUM_KW; k++) begin
			if (name_len_q >= kw_len(2'(k)) || kw_char(2'(k), name_len_q) != line_byte)
				cand_next[k] = 1'b0;
		end
	end

	// terminator report
	always_comb begin
		end_kind = KIND_NONE;
		if (!comment_q) begin
			case (phase_q)
				PH_NAME:  end_kind = matched_kind(cand_q, name_len_q);
				PH_VALUE: end_kind = vkind_q;
				default:  end_kind = KIND_NONE;
			endcase
		end
		end_bad = (end_kind == KIND_RETRY) &&
			(phase_q != PH_VALUE || rstat.invalid || !rstat.seen_digit);
	end

	assign vbyte_fwd = !end_of_line && !comment_q && phase_q == PH_VALUE && !drop_space
		&& (vkind_q == KIND_EVENT || vkind_q == KIND_DATA || vkind_q == KIND_ID);

	assign rctl.clear = step && end_of_line;
	assign rctl.feed  = step && !end_of_line && !comment_q && phase_q == PH_VALUE
		&& !drop_space && vkind_q == KIND_RETRY;
	assign rctl.data  = line_byte;

	assign produce = end_of_line || vbyte_fwd;

	always_comb begin
		if (end_of_line) begin
			res.value_valid = 1'b0;
			res.value_byte  = '0;
			res.line_done   = 1'b1;
			res.kind        = end_kind;
			res.status      = end_bad;
			res.retry_value = (end_kind == KIND_RETRY && !end_bad) ? rstat.value : '0;
		end else begin
			res.value_valid = 1'b1;
			res.value_byte  = line_byte;
			res.line_done   = 1'b0;
			res.kind        = vkind_q;
			res.status      = 1'b0;
			res.retry_value = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			name_len_q <= '0;
			cand_q     <= '1;
			comment_q  <= 1'b0;
			vkind_q    <= KIND_NONE;
			first_q    <= 1'b0;
		end else if (step) begin
			if (end_of_line) begin
				phase_q    <= PH_START;
				name_len_q <= '0;
				cand_q     <= '1;
				comment_q  <= 1'b0;
				vkind_q    <= KIND_NONE;
				first_q    <= 1'b0;
			end else if (!comment_q) begin
				case (phase_q)
					PH_START, PH_NAME: begin
						if (is_colon && phase_q == PH_START) begin
							comment_q <= 1'b1;
						end else if (is_colon) begin
							vkind_q <= matched_kind(cand_q, name_len_q);
							phase_q <= PH_VALUE;
							first_q <= 1'b1;
						end else begin
							phase_q <= PH_NAME;
							cand_q  <= cand_next;
							if (name_len_q != 3'(NAME_LEN_MAX))
								name_len_q <= name_len_q + 3'd1;
						end
					end
					PH_VALUE: begin
						first_q <= 1'b0;
					end
					default: begin
						phase_q <= PH_START;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/event_stream_field_line_parser_unit.sv */
// Top level of the event-stream field line parser: input register, parser, result register.
//
// Input channel (in_valid/in_ready): one word per line byte, or a terminator word
// with end_of_line high (line_byte ignored). Output channel (out_valid/out_ready):
// one word per forwarded value byte of an event, data or id field, and exactly one
// word per terminator carrying line_done, field_kind, status and retry_value.
// Bytes of comment lines, field names, unknown fields and retry values give no word.
// A word goes from the input register through the parser to the result register.
// One input word per cycle while the receiver does not stall; the name match path
// to the result register and the retry multiply-by-ten add are combinational.
// A finished result may sit in the output register while the next word is taken
// into the input register. If the receiver stalls with a result pending, the input
// register holds and in_ready drops once it is full; nothing is lost or repeated.
// Reset (arst_n low) empties both registers and returns the line state to line
// start with all four keywords possible.
`default_nettype none

module event_stream_field_line_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  line_byte,
	input  wire logic        end_of_line,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             value_valid,
	output logic [7:0]       value_byte,
	output logic             line_done,
	output logic [2:0]       field_kind,
	output logic             status,
	output logic [30:0]      retry_value
);
	import esflp_pkg::*;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eol_s1;

	// result register
	logic        res_valid_q;
	res_t        res_q;

	logic        res_free;
	logic        step;
	logic        produce;
	res_t        res_next;
	retry_ctl_t  rctl;
	retry_stat_t rstat;

	assign res_free = !res_valid_q || out_ready;
	assign step     = valid_s1 && res_free;
	assign in_ready = !valid_s1 || res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= line_byte;
			eol_s1  <= end_of_line;
		end
	end

	esflp_line_ctl u_line_ctl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.line_byte   (byte_s1),
		.end_of_line (eol_s1),
		.rstat       (rstat),
		.rctl        (rctl),
		.produce     (produce),
		.res         (res_next)
	);

	esflp_retry u_retry (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rctl),
		.stat   (rstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (res_free)
			res_valid_q <= step && produce;
	end

	always_ff @(posedge clk) begin
		if (step && produce)
			res_q <= res_next;
	end

	assign out_valid   = res_valid_q;
	assign value_valid = res_q.value_valid;
	assign value_byte  = res_q.value_byte;
	assign line_done   = res_q.line_done;
	assign field_kind  = res_q.kind;
	assign status      = res_q.status;
	assign retry_value = res_q.retry_value;

	// a result is either a value byte or a line report
	a_one_role: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (value_valid != line_done))
		else $error("result word is neither or both of value byte and line report");

	// invalid status only on retry lines
	a_status_retry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> line_done && field_kind == KIND_RETRY)
		else $error("invalid status on a non-retry result");

	// a retry value only shows on a successful retry line
	a_retry_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && retry_value != '0 |-> field_kind == KIND_RETRY && !status)
		else $error("retry value on a result that is not a good retry line");

	// an empty result register never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty result register");

endmodule

`default_nettype wire
